/* rtl/dtl_pkg.sv */
// ----------------------------------------------------------------------------
// dtl_pkg: shared types for the deadline task list
// Operation and status codes, controller states, and the command and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dtl_pkg;

  localparam int unsigned IdW     = 32;
  localparam int unsigned DlW     = 32;
  localparam int unsigned CntOutW = 5;

  // operation codes on kind
  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_SORT   = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // one stored task
  typedef struct packed {
    logic [IdW-1:0] id;
    logic [DlW-1:0] dl;
  } entry_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_WAIT,
    S_RM_CMP,
    S_RM_NEXT,
    S_RM_MOVE,
    S_SO_OUTER,
    S_SO_KEY,
    S_SO_CMP,
    S_SO_STEP,
    S_FINISH
  } state_e;

  // logical slot read each cycle
  typedef enum logic [1:0] {
    RD_IDX    = 2'd0,
    RD_IDX_P1 = 2'd1,
    RD_JDX_M1 = 2'd2
  } rd_src_e;

  // memory write selection
  typedef enum logic [2:0] {
    WR_NONE     = 3'd0,
    WR_PUSH     = 3'd1,
    WR_IDX      = 3'd2,
    WR_JDX_DATA = 3'd3,
    WR_JDX_KEY  = 3'd4
  } wr_src_e;

  // result register update
  typedef enum logic [2:0] {
    RES_NONE      = 3'd0,
    RES_EMPTY     = 3'd1,
    RES_NOT_FOUND = 3'd2,
    RES_FULL      = 3'd3,
    RES_TAKE      = 3'd4
  } res_e;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    idx_set_one;
    logic    idx_inc;
    logic    jdx_from_idx;
    logic    jdx_dec;
    logic    key_load;
    rd_src_e rd_src;
    wr_src_e wr_src;
    logic    push_commit;
    logic    pop_commit;
    logic    cnt_dec;
    res_e    res_set;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  cnt_zero;
    logic  full;
    logic  idx_lt_cnt;
    logic  idx_p1_lt_cnt;
    logic  jdx_nz;
    logic  id_match;
    logic  dl_greater;
    logic  out_free;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/deadline_task_list_core.sv */
// ----------------------------------------------------------------------------
// deadline_task_list_core: bounded task list with earliest-deadline sort
// Push to front, pop front, remove first matching id, stable sort by
// deadline. One result per operation.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------------
//   in       | in_valid_i / in_stall_o | kind_i, task_id_i, deadline_i
//   out      | out_valid_o/out_stall_i | status_o, out_task_id_o,
//            |                         | out_deadline_o, entry_count_o
//
// Remove and sort take longer the more tasks are stored, since the task
// memory is walked with one read or write per cycle.
// One operation is in flight at a time; the next transfer is taken once the
// result is in the output register, even while that result is stalled.
// Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_task_list_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [1:0]                    kind_i,
  input  wire logic [dtl_pkg::IdW-1:0]       task_id_i,
  input  wire logic [dtl_pkg::DlW-1:0]       deadline_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [1:0]                    status_o,
  output      logic [dtl_pkg::IdW-1:0]       out_task_id_o,
  output      logic [dtl_pkg::DlW-1:0]       out_deadline_o,
  output      logic [dtl_pkg::CntOutW-1:0]   entry_count_o
);
  import dtl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  dtl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage and result path
  dtl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (kind_i),
    .task_id_i      (task_id_i),
    .deadline_i     (deadline_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_task_id_o  (out_task_id_o),
    .out_deadline_o (out_deadline_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

`default_nettype wire

/* rtl/dtl_datapath.sv */
// ----------------------------------------------------------------------------
// dtl_datapath: task storage and list bookkeeping
// Ring-addressed task memory with head pointer and count, scan indices,
// sort key, result registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtl_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dtl_pkg::cmd_t                 cmd_i,
  output      dtl_pkg::stat_t                stat_o,
  input  wire logic [1:0]                    kind_i,
  input  wire logic [dtl_pkg::IdW-1:0]       task_id_i,
  input  wire logic [dtl_pkg::DlW-1:0]       deadline_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [1:0]                    status_o,
  output      logic [dtl_pkg::IdW-1:0]       out_task_id_o,
  output      logic [dtl_pkg::DlW-1:0]       out_deadline_o,
  output      logic [dtl_pkg::CntOutW-1:0]   entry_count_o
);
  import dtl_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;

  // logical slot to memory address, head plus offset wrapped once
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] lg);
    logic [SW-1:0] s;
    s = SW'(hd) + SW'(lg);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  entry_t          mem_q [CAPACITY];
  entry_t          rd_data_q;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  kind_e           op_kind_q;
  logic [IdW-1:0]  op_id_q;
  logic [DlW-1:0]  op_dl_q;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   jdx_q, jdx_d;
  entry_t          key_q;
  status_e         res_status_q, res_status_d;
  logic [IdW-1:0]  res_id_q, res_id_d;
  logic [DlW-1:0]  res_dl_q, res_dl_d;
  logic            out_valid_q;
  status_e         out_status_q;
  logic [IdW-1:0]  out_id_q;
  logic [DlW-1:0]  out_dl_q;
  logic [CntOutW-1:0] out_cnt_q;

  logic [AW-1:0]   head_dec, head_inc;
  logic [SW-1:0]   idx_p1;
  logic [CW-1:0]   jdx_m1;

  assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
  assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
  assign idx_p1   = SW'(idx_q) + 1'b1;
  assign jdx_m1   = jdx_q - 1'b1;

  // status toward the controller
  always_comb begin
    stat_o.kind          = op_kind_q;
    stat_o.cnt_zero      = (count_q == '0);
    stat_o.full          = (count_q == CW'(CAPACITY));
    stat_o.idx_lt_cnt    = (idx_q < count_q);
    stat_o.idx_p1_lt_cnt = (idx_p1 < SW'(count_q));
    stat_o.jdx_nz        = (jdx_q != '0);
    stat_o.id_match      = (rd_data_q.id == op_id_q);
    stat_o.dl_greater    = (rd_data_q.dl > key_q.dl);
    stat_o.out_free      = !out_valid_q || !out_stall_i;
  end

  // read address select
  always_comb begin
    case (cmd_i.rd_src)
      RD_IDX_P1: rd_addr = phys(head_q, idx_p1[CW-1:0]);
      RD_JDX_M1: rd_addr = phys(head_q, jdx_m1);
      default:   rd_addr = phys(head_q, idx_q);
    endcase
  end

  // write port select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = phys(head_q, jdx_q);
    wr_data = rd_data_q;
    case (cmd_i.wr_src)
      WR_PUSH: begin
        wr_addr    = head_dec;
        wr_data.id = op_id_q;
        wr_data.dl = op_dl_q;
      end
      WR_IDX: begin
        wr_addr = phys(head_q, idx_q);
      end
      WR_JDX_DATA: begin
        wr_addr = phys(head_q, jdx_q);
      end
      WR_JDX_KEY: begin
        wr_data = key_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // task memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // list bookkeeping next state
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.push_commit) begin
      head_d  = head_dec;
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop_commit) begin
      head_d  = head_inc;
      count_d = count_q - 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end
  end

  // scan indices next state
  always_comb begin
    idx_d = idx_q;
    jdx_d = jdx_q;
    if (cmd_i.latch) begin
      idx_d = '0;
    end else if (cmd_i.idx_set_one) begin
      idx_d = CW'(1);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.jdx_from_idx) begin
      jdx_d = idx_q;
    end else if (cmd_i.jdx_dec) begin
      jdx_d = jdx_m1;
    end
  end

  // result next state
  always_comb begin
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_dl_d     = res_dl_q;
    if (cmd_i.latch) begin
      res_status_d = ST_OK;
      res_id_d     = '0;
      res_dl_d     = '0;
    end else begin
      case (cmd_i.res_set)
        RES_EMPTY:     res_status_d = ST_EMPTY;
        RES_NOT_FOUND: res_status_d = ST_NOT_FOUND;
        RES_FULL:      res_status_d = ST_FULL;
        RES_TAKE: begin
          res_status_d = ST_OK;
          res_id_d     = rd_data_q.id;
          res_dl_d     = rd_data_q.dl;
        end
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_kind_q <= kind_e'(kind_i);
      op_id_q   <= task_id_i;
      op_dl_q   <= deadline_i;
    end
    if (cmd_i.key_load) begin
      key_q <= rd_data_q;
    end
    idx_q        <= idx_d;
    jdx_q        <= jdx_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_dl_q     <= res_dl_d;
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_dl_q     <= res_dl_q;
      out_cnt_q    <= CntOutW'(count_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_task_id_o  = out_id_q;
  assign out_deadline_o = out_dl_q;
  assign entry_count_o  = out_cnt_q;

endmodule

`default_nettype wire

/* rtl/dtl_ctrl.sv */
// ----------------------------------------------------------------------------
// dtl_ctrl: operation sequencer for the deadline task list
// Walks push, pop, remove-by-id and insertion sort through the datapath
// one memory access per cycle, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtl_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire dtl_pkg::stat_t  stat_i,
  output      dtl_pkg::cmd_t   cmd_o
);
  import dtl_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.kind)
          KIND_PUSH: begin
            if (stat_i.full) begin
              cmd_o.res_set = RES_FULL;
            end else begin
              cmd_o.wr_src      = WR_PUSH;
              cmd_o.push_commit = 1'b1;
            end
            state_d = S_FINISH;
          end
          KIND_POP: begin
            if (stat_i.cnt_zero) begin
              cmd_o.res_set = RES_EMPTY;
              state_d       = S_FINISH;
            end else begin
              cmd_o.rd_src = RD_IDX;
              state_d      = S_POP_WAIT;
            end
          end
          KIND_REMOVE: begin
            if (stat_i.cnt_zero) begin
              cmd_o.res_set = RES_NOT_FOUND;
              state_d       = S_FINISH;
            end else begin
              cmd_o.rd_src = RD_IDX;
              state_d      = S_RM_CMP;
            end
          end
          default: begin
            cmd_o.idx_set_one = 1'b1;
            state_d           = S_SO_OUTER;
          end
        endcase
      end
      S_POP_WAIT: begin
        cmd_o.res_set    = RES_TAKE;
        cmd_o.pop_commit = 1'b1;
        state_d          = S_FINISH;
      end
      // compare the scanned id, step to the next slot on a miss
      S_RM_CMP: begin
        if (stat_i.id_match) begin
          cmd_o.res_set = RES_TAKE;
          state_d       = S_RM_NEXT;
        end else if (stat_i.idx_p1_lt_cnt) begin
          cmd_o.idx_inc = 1'b1;
          cmd_o.rd_src  = RD_IDX_P1;
        end else begin
          cmd_o.res_set = RES_NOT_FOUND;
          state_d       = S_FINISH;
        end
      end
      // close the gap: move each later slot down by one
      S_RM_NEXT: begin
        if (stat_i.idx_p1_lt_cnt) begin
          cmd_o.rd_src = RD_IDX_P1;
          state_d      = S_RM_MOVE;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FINISH;
        end
      end
      S_RM_MOVE: begin
        cmd_o.wr_src  = WR_IDX;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_RM_NEXT;
      end
      // insertion sort outer loop
      S_SO_OUTER: begin
        if (stat_i.idx_lt_cnt) begin
          cmd_o.rd_src       = RD_IDX;
          cmd_o.jdx_from_idx = 1'b1;
          state_d            = S_SO_KEY;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SO_KEY: begin
        cmd_o.key_load = 1'b1;
        cmd_o.rd_src   = RD_JDX_M1;
        state_d        = S_SO_CMP;
      end
      // shift a later-deadline slot up, or drop the key in place
      S_SO_CMP: begin
        if (stat_i.dl_greater) begin
          cmd_o.wr_src  = WR_JDX_DATA;
          cmd_o.jdx_dec = 1'b1;
          state_d       = S_SO_STEP;
        end else begin
          cmd_o.wr_src  = WR_JDX_KEY;
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SO_OUTER;
        end
      end
      S_SO_STEP: begin
        if (stat_i.jdx_nz) begin
          cmd_o.rd_src = RD_JDX_M1;
          state_d      = S_SO_CMP;
        end else begin
          cmd_o.wr_src  = WR_JDX_KEY;
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SO_OUTER;
        end
      end
      // wait for the output register to free up
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* bench/tb_deadline_task_list_core.sv */
// ----------------------------------------------------------------------------
// tb_deadline_task_list_core: self-checking bench for the deadline task list
// Drives push, pop, remove-by-id and stable sort operations through the
// valid/stall input channel. A behavioral copy of the list works out each
// result at transfer time. The output side stalls at random, and every
// result is compared field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_deadline_task_list_core;

  import dtl_pkg::*;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_WAIT    = 18;

  // one result as the block reports it
  typedef struct packed {
    status_e              status;
    logic [IdW-1:0]       id;
    logic [DlW-1:0]       dl;
    logic [CntOutW-1:0]   cnt;
  } outcome_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           kind_i        = '0;
  logic [IdW-1:0]       task_id_i     = '0;
  logic [DlW-1:0]       deadline_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [1:0]           status_o;
  logic [IdW-1:0]       out_task_id_o;
  logic [DlW-1:0]       out_deadline_o;
  logic [CntOutW-1:0]   entry_count_o;

  // shadow copy of the task list, front at slot 0
  entry_t      shadow_slots [CAPACITY];
  int unsigned shadow_len;

  outcome_t    pending_outcomes [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          no_idle;

  deadline_task_list_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .task_id_i     (task_id_i),
    .deadline_i    (deadline_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_task_id_o (out_task_id_o),
    .out_deadline_o(out_deadline_o),
    .entry_count_o (entry_count_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // idle cycles before a transfer, or before releasing after one
  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // apply one operation to the shadow list and return its result
  function automatic outcome_t task_list_apply(kind_e op, logic [IdW-1:0] id,
                                               logic [DlW-1:0] dl);
    outcome_t r;
    int       pos;
    entry_t   key;
    int       j;
    r        = '0;
    r.status = ST_OK;
    pos      = -1;
    case (op)
      KIND_PUSH: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > 0; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[0].id = id;
          shadow_slots[0].dl = dl;
          shadow_len++;
        end
      end
      KIND_POP: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else pos = 0;
      end
      KIND_REMOVE: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (pos < 0 && shadow_slots[i].id == id) pos = i;
        end
        if (pos < 0) r.status = ST_NOT_FOUND;
      end
      default: begin
        // insertion sort keeps equal deadlines in order
        for (int i = 1; i < shadow_len; i++) begin
          key = shadow_slots[i];
          j   = i;
          while (j > 0 && shadow_slots[j-1].dl > key.dl) begin
            shadow_slots[j] = shadow_slots[j-1];
            j--;
          end
          shadow_slots[j] = key;
        end
      end
    endcase
    // unlink the taken task and close the gap
    if (pos >= 0) begin
      r.id = shadow_slots[pos].id;
      r.dl = shadow_slots[pos].dl;
      for (int i = pos; i + 1 < shadow_len; i++) shadow_slots[i] = shadow_slots[i+1];
      shadow_len--;
    end
    r.cnt = shadow_len[CntOutW-1:0];
    return r;
  endfunction

  // one input transfer; valid stays high afterwards unless the next call idles or the results are drained
  task automatic send_op(kind_e op, logic [IdW-1:0] id, logic [DlW-1:0] dl);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= op;
    task_id_i  <= id;
    deadline_i <= dl;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_outcomes.push_back(task_list_apply(op, id, dl));
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result checker and output stall generator
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result expected none actual status %h id %h dl %h cnt %h",
                 $time, status_o, out_task_id_o, out_deadline_o, entry_count_o);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("out_task_id", want.id, out_task_id_o);
        check_field("out_deadline", want.dl, out_deadline_o);
        check_field("entry_count", 32'(want.cnt), 32'(entry_count_o));
      end
      stall_left = draw_wait();
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // empty-list flags, then a single task
  task automatic test_empty_list();
    send_op(KIND_POP, 32'h1234_5678, 32'h0);
    send_op(KIND_REMOVE, 32'h0, 32'h0);
    send_op(KIND_SORT, 32'h0, 32'h0);
    send_op(KIND_PUSH, 32'hFFFF_FFFF, 32'h0);
    send_op(KIND_SORT, 32'h0, 32'hFFFF_FFFF);
    send_op(KIND_POP, 32'h0, 32'h0);
  endtask

  // fill to capacity with ties, duplicates and extreme values, then overflow, sort, remove and pop
  task automatic test_full_list();
    logic [IdW-1:0] id;
    logic [DlW-1:0] dl;
    for (int i = 0; i < CAPACITY; i++) begin
      id = (i % 5 == 0) ? 32'h7 : 32'hA5A5_0000 + i;
      if (i == 3) id = 32'h0;
      if (i == CAPACITY - 1) id = 32'hFFFF_FFFF;
      dl = (i % 4 == 0) ? 32'd50 : 32'h8000_0000 - i;
      if (i == 1) dl = 32'hFFFF_FFFF;
      if (i == 2) dl = 32'h0;
      send_op(KIND_PUSH, id, dl);
    end
    send_op(KIND_PUSH, 32'h5A5A_5A5A, 32'h1);
    send_op(KIND_SORT, 32'h0, 32'h0);
    send_op(KIND_REMOVE, 32'h7, 32'h0);
    send_op(KIND_POP, 32'h0, 32'h0);
  endtask

  // random mix in phases that lean toward filling or emptying the list
  task automatic test_random_mix(int unsigned n);
    int unsigned    push_pct;
    int unsigned    roll;
    logic [IdW-1:0] id;
    logic [DlW-1:0] dl;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 20;
          1:       push_pct = 45;
          default: push_pct = 75;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (k % 200 == 100) drain_results();
      roll = $urandom_range(0, 99);
      // small id pool makes duplicates and hits likely
      id = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
      case ($urandom_range(0, 9))
        0:             dl = 32'hFFFF_FFFF;
        1:             dl = 32'h0;
        2, 3, 4, 5:    dl = 32'($urandom_range(0, 15));
        default:       dl = $urandom;
      endcase
      if (roll < push_pct) begin
        send_op(KIND_PUSH, id, dl);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          send_op(KIND_POP, id, dl);
        end else if (roll < 85) begin
          if (shadow_len > 0 && $urandom_range(0, 9) < 7)
            id = shadow_slots[$urandom_range(0, shadow_len - 1)].id;
          send_op(KIND_REMOVE, id, dl);
        end else begin
          send_op(KIND_SORT, id, dl);
        end
      end
    end
  endtask

  initial begin
    shadow_len  = 0;
    mismatches  = 0;
    cycle_count = 0;
    stall_left  = 0;
    no_idle     = 1'b0;
    for (int i = 0; i < CAPACITY; i++) shadow_slots[i] = '0;

    // reset
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    drain_results();
    test_full_list();
    drain_results();
    test_random_mix(800);
    drain_results();

    // leave room for any stray result after the last one
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
